FILE: rtl/core/has_pkg.sv
`default_nettype none

package has_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    localparam logic [4:0] PREFIX_LEN = 5'd21;
    localparam logic [4:0] FIXED_LEN  = 5'd18;

    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // command kinds handed from parser to emitter
    typedef enum logic [1:0] {
        CMD_BYTES = 2'd0,
        CMD_DONE  = 2'd1,
        CMD_FIXED = 2'd2
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic       two;      // CMD_BYTES: second byte present
        logic [7:0] b0;
        logic [7:0] b1;
        logic       verdict;  // CMD_DONE: line is a heading
    } cmd_t;

    function automatic logic is_ws(input logic [7:0] c);
        is_ws = (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'd48) && (c <= 8'd57);
    endfunction

    function automatic logic is_upper(input logic [7:0] c);
        is_upper = (c >= 8'd65) && (c <= 8'd90);
    endfunction

    function automatic logic is_alnum(input logic [7:0] c);
        is_alnum = is_digit(c) || is_upper(c) || (c >= 8'd97 && c <= 8'd122);
    endfunction

    // "## Where this is used"
    function automatic logic [7:0] prefix_char(input logic [4:0] idx);
        logic [7:0] r;
        unique case (idx)
            5'd0, 5'd1:   r = 8'h23;
            5'd2:         r = 8'h20;
            5'd3:         r = 8'h57;
            5'd4:         r = 8'h68;
            5'd5:         r = 8'h65;
            5'd6:         r = 8'h72;
            5'd7:         r = 8'h65;
            5'd8:         r = 8'h20;
            5'd9:         r = 8'h74;
            5'd10:        r = 8'h68;
            5'd11:        r = 8'h69;
            5'd12:        r = 8'h73;
            5'd13:        r = 8'h20;
            5'd14:        r = 8'h69;
            5'd15:        r = 8'h73;
            5'd16:        r = 8'h20;
            5'd17:        r = 8'h75;
            5'd18:        r = 8'h73;
            5'd19:        r = 8'h65;
            5'd20:        r = 8'h64;
            default:      r = 8'h00;
        endcase
        return r;
    endfunction

    // "where-this-is-used"
    function automatic logic [7:0] fixed_char(input logic [4:0] idx);
        logic [7:0] r;
        unique case (idx)
            5'd0:         r = 8'h77;
            5'd1:         r = 8'h68;
            5'd2:         r = 8'h65;
            5'd3:         r = 8'h72;
            5'd4:         r = 8'h65;
            5'd5:         r = 8'h2D;
            5'd6:         r = 8'h74;
            5'd7:         r = 8'h68;
            5'd8:         r = 8'h69;
            5'd9:         r = 8'h73;
            5'd10:        r = 8'h2D;
            5'd11:        r = 8'h69;
            5'd12:        r = 8'h73;
            5'd13:        r = 8'h2D;
            5'd14:        r = 8'h75;
            5'd15:        r = 8'h73;
            5'd16:        r = 8'h65;
            5'd17:        r = 8'h64;
            default:      r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/has_front.sv
`default_nettype none

module has_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    char_byte,
    input  wire logic          line_end,
    input  wire logic          q_full,
    output logic               q_push,
    output has_pkg::cmd_t      q_cmd
);
    import has_pkg::*;

    typedef enum logic [7:0] {
        PH_HASH = 8'b0000_0001,
        PH_WS1  = 8'b0000_0010,
        PH_INT  = 8'b0000_0100,
        PH_DOT1 = 8'b0000_1000,
        PH_FRAC = 8'b0001_0000,
        PH_DOT2 = 8'b0010_0000,
        PH_SLUG = 8'b0100_0000,
        PH_FAIL = 8'b1000_0000
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [1:0] hash_cnt_reg, hash_cnt_next;
    logic [4:0] pfx_pos_reg, pfx_pos_next;
    logic       pfx_alive_reg, pfx_alive_next;
    logic       slug_nonempty_reg, slug_nonempty_next;
    logic       dash_pending_reg, dash_pending_next;

    logic       accept;
    logic       emit;
    cmd_t       cmd;
    logic [7:0] c;
    logic [7:0] c_low;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign q_push   = accept && emit;
    assign q_cmd    = cmd;
    assign c        = char_byte;
    assign c_low    = is_upper(c) ? (c | 8'h20) : c;

    always_comb
    begin
        phase_next         = phase_reg;
        hash_cnt_next      = hash_cnt_reg;
        pfx_pos_next       = pfx_pos_reg;
        pfx_alive_next     = pfx_alive_reg;
        slug_nonempty_next = slug_nonempty_reg;
        dash_pending_next  = dash_pending_reg;
        emit               = 1'b0;
        cmd.kind           = CMD_BYTES;
        cmd.two            = 1'b0;
        cmd.b0             = c;
        cmd.b1             = c;
        cmd.verdict        = 1'b0;

        if (line_end) begin
            emit = 1'b1;
            if (pfx_alive_reg && pfx_pos_reg == PREFIX_LEN) begin
                cmd.kind = CMD_FIXED;
            end else begin
                cmd.kind    = CMD_DONE;
                cmd.verdict = (phase_reg == PH_SLUG);
            end
            phase_next         = PH_HASH;
            hash_cnt_next      = 2'd0;
            pfx_pos_next       = 5'd0;
            pfx_alive_next     = 1'b1;
            slug_nonempty_next = 1'b0;
            dash_pending_next  = 1'b0;
        end else begin
            if (pfx_alive_reg && pfx_pos_reg < PREFIX_LEN) begin
                if (c == prefix_char(pfx_pos_reg))
                    pfx_pos_next = pfx_pos_reg + 5'd1;
                else
                    pfx_alive_next = 1'b0;
            end

            unique case (phase_reg)
                PH_HASH:
                begin
                    if (c == CH_HASH) begin
                        if (hash_cnt_reg == 2'd3)
                            phase_next = PH_FAIL;
                        else
                            hash_cnt_next = hash_cnt_reg + 2'd1;
                    end else if (is_ws(c) && hash_cnt_reg >= 2'd2) begin
                        phase_next = PH_WS1;
                    end else begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_WS1:
                begin
                    if (is_digit(c)) begin
                        emit       = 1'b1;
                        phase_next = PH_INT;
                    end else if (!is_ws(c)) begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_INT, PH_FRAC:
                begin
                    if (is_digit(c)) begin
                        emit = 1'b1;
                    end else if (c == CH_DOT) begin
                        phase_next = (phase_reg == PH_INT) ? PH_DOT1 : PH_DOT2;
                    end else if (is_ws(c)) begin
                        emit       = 1'b1;
                        cmd.b0     = CH_DASH;
                        phase_next = PH_SLUG;
                    end else begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_DOT1:
                begin
                    // deferred dot goes out with the digit after it
                    if (is_digit(c)) begin
                        emit       = 1'b1;
                        cmd.two    = 1'b1;
                        cmd.b0     = CH_DOT;
                        phase_next = PH_FRAC;
                    end else if (is_ws(c)) begin
                        emit       = 1'b1;
                        cmd.b0     = CH_DASH;
                        phase_next = PH_SLUG;
                    end else begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_DOT2:
                begin
                    if (is_ws(c)) begin
                        emit       = 1'b1;
                        cmd.b0     = CH_DASH;
                        phase_next = PH_SLUG;
                    end else begin
                        phase_next = PH_FAIL;
                    end
                end
                PH_SLUG:
                begin
                    if (c == CH_DOLLAR) begin
                        // dropped
                    end else if (is_alnum(c)) begin
                        emit   = 1'b1;
                        cmd.b1 = c_low;
                        if (dash_pending_reg && slug_nonempty_reg) begin
                            cmd.two = 1'b1;
                            cmd.b0  = CH_DASH;
                        end else begin
                            cmd.b0  = c_low;
                        end
                        dash_pending_next  = 1'b0;
                        slug_nonempty_next = 1'b1;
                    end else begin
                        dash_pending_next = 1'b1;
                    end
                end
                default:
                begin
                    phase_next = PH_FAIL;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg         <= PH_HASH;
            hash_cnt_reg      <= 2'd0;
            pfx_pos_reg       <= 5'd0;
            pfx_alive_reg     <= 1'b1;
            slug_nonempty_reg <= 1'b0;
            dash_pending_reg  <= 1'b0;
        end else if (accept) begin
            phase_reg         <= phase_next;
            hash_cnt_reg      <= hash_cnt_next;
            pfx_pos_reg       <= pfx_pos_next;
            pfx_alive_reg     <= pfx_alive_next;
            slug_nonempty_reg <= slug_nonempty_next;
            dash_pending_reg  <= dash_pending_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/has_queue.sv
`default_nettype none

module has_queue #(
    parameter int unsigned DEPTH = has_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire has_pkg::cmd_t push_cmd,
    output logic               full,
    input  wire logic          pop,
    output logic               empty,
    output has_pkg::cmd_t      head_cmd
);
    import has_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    cmd_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign head_cmd = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/has_back.sv
`default_nettype none

module has_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          q_empty,
    input  wire has_pkg::cmd_t q_head,
    output logic               q_pop,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [7:0]         anchor_byte,
    output logic               line_done,
    output logic               anchor_valid
);
    import has_pkg::*;

    logic [4:0] idx_reg;
    logic       last;
    logic       beat;

    assign out_valid = !q_empty;
    assign beat      = out_valid && out_ready;
    assign q_pop     = beat && last;

    always_comb
    begin
        anchor_byte  = CH_NUL;
        line_done    = 1'b0;
        anchor_valid = 1'b0;
        last         = 1'b1;
        unique case (q_head.kind)
            CMD_BYTES:
            begin
                anchor_byte = (idx_reg == 5'd0) ? q_head.b0 : q_head.b1;
                last        = !q_head.two || (idx_reg != 5'd0);
            end
            CMD_DONE:
            begin
                line_done    = 1'b1;
                anchor_valid = q_head.verdict;
            end
            CMD_FIXED:
            begin
                // 18 fixed bytes, then the verdict beat
                if (idx_reg < FIXED_LEN) begin
                    anchor_byte = fixed_char(idx_reg);
                    last        = 1'b0;
                end else begin
                    line_done    = 1'b1;
                    anchor_valid = 1'b1;
                end
            end
            default:
            begin
                line_done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            idx_reg <= 5'd0;
        else if (beat)
            idx_reg <= last ? 5'd0 : idx_reg + 5'd1;
    end

endmodule

`default_nettype wire

FILE: rtl/core/heading_anchor_slugger_core.sv
`default_nettype none

// Channel | Direction | Handshake             | Payload
// input   | in        | in_valid / in_ready   | char_byte, line_end
// output  | out       | out_valid / out_ready | anchor_byte, line_done, anchor_valid
//
// One input beat per cycle while the command queue has room; the parser
// turns each beat into at most one queued command in the same cycle.
// The emitter drains one output beat per cycle while out_ready is high: most
// commands are one beat, a dot or dash pair is two, the fixed anchor is 19
// (18 bytes plus verdict). Output stalls back up only through the queue
// (QUEUE_DEPTH commands). Reset clears parser state and empties the queue.

module heading_anchor_slugger_core #(
    parameter int unsigned QUEUE_DEPTH = has_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic [7:0] char_byte,
    input  wire logic       line_end,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [7:0]      anchor_byte,
    output logic            line_done,
    output logic            anchor_valid
);
    import has_pkg::*;

    logic q_push, q_pop, q_full, q_empty;
    cmd_t push_cmd, head_cmd;

    has_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .char_byte (char_byte),
        .line_end  (line_end),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    has_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .empty    (q_empty),
        .head_cmd (head_cmd)
    );

    has_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (head_cmd),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .anchor_byte  (anchor_byte),
        .line_done    (line_done),
        .anchor_valid (anchor_valid)
    );

endmodule

`default_nettype wire
